>>> rtl/drbf_pkg.sv
// ----------------------------------------------------------------------------
// drbf_pkg
// shared constants, types and helpers of the dual reader byte fifo
// ----------------------------------------------------------------------------
`default_nettype none

package drbf_pkg;

    // ring size and read burst cap
    localparam int BUFFER_SLOTS   = 1024;
    localparam int MAX_READ_BURST = 64;

    localparam int IDX_W   = $clog2(BUFFER_SLOTS);
    localparam int CNT_W   = $clog2(MAX_READ_BURST + 1);
    localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int STAT_W  = 10;
    localparam int MOVED_W = 10;
    localparam int REQ_W   = 7;

    localparam logic [IDX_W:0] SLOTS_X = (IDX_W + 1)'(BUFFER_SLOTS);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_READ_A = 2'd1,
        K_READ_B = 2'd2,
        K_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_BURST
    } state_t;

    typedef struct packed {
        idx_t level_a;
        idx_t level_b;
        idx_t free_space;
    } status_t;

    // ring increment with wrap
    function automatic idx_t next_idx(input idx_t i);
        next_idx = (i == IDX_W'(BUFFER_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/drbf_in_if.sv
// ----------------------------------------------------------------------------
// drbf_in_if
// item channel: valid/ready handshake with write and read request payload
// ----------------------------------------------------------------------------
`default_nettype none

interface drbf_in_if;
    logic                valid;
    logic                ready;
    drbf_pkg::kind_t     kind;
    logic [7:0]          data_byte;
    logic                burst_last;
    logic [6:0]          count;
    logic                discard;

    modport source (
        output valid, kind, data_byte, burst_last, count, discard,
        input  ready
    );

    modport sink (
        input  valid, kind, data_byte, burst_last, count, discard,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/drbf_out_if.sv
// ----------------------------------------------------------------------------
// drbf_out_if
// result channel: valid/ready handshake with byte and status payload
// ----------------------------------------------------------------------------
`default_nettype none

interface drbf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic        byte_valid;
    logic        last;
    logic        write_accepted;
    logic [9:0]  moved_count;
    logic [9:0]  free_space;
    logic [9:0]  level_a;
    logic [9:0]  level_b;

    modport source (
        output valid, read_byte, byte_valid, last, write_accepted,
               moved_count, free_space, level_a, level_b,
        input  ready
    );

    modport sink (
        input  valid, read_byte, byte_valid, last, write_accepted,
               moved_count, free_space, level_a, level_b,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/drbf_status.sv
// ----------------------------------------------------------------------------
// drbf_status
// reader levels and free space from the three ring indices
// ----------------------------------------------------------------------------
`default_nettype none

module drbf_status (
    input  drbf_pkg::idx_t    write_index,
    input  drbf_pkg::idx_t    reader_a_index,
    input  drbf_pkg::idx_t    reader_b_index,
    output drbf_pkg::status_t status
);
    import drbf_pkg::*;

    idx_t lvl_a;
    idx_t lvl_b;
    idx_t lvl_hi;

    function automatic idx_t level_of(input idx_t w, input idx_t r);
        level_of = (w >= r) ? w - r
                            : IDX_W'({1'b0, w} + SLOTS_X - {1'b0, r});
    endfunction

    always_comb
    begin
        lvl_a  = level_of(write_index, reader_a_index);
        lvl_b  = level_of(write_index, reader_b_index);
        lvl_hi = (lvl_a > lvl_b) ? lvl_a : lvl_b;
        status.level_a    = lvl_a;
        status.level_b    = lvl_b;
        // space only opens up behind the slower reader
        status.free_space = IDX_W'(BUFFER_SLOTS - 1) - lvl_hi;
    end

endmodule

`default_nettype wire

>>> rtl/dual_reader_byte_fifo_unit.sv
// ----------------------------------------------------------------------------
// dual_reader_byte_fifo_unit
// byte ring buffer with one writer and two independent readers
// ----------------------------------------------------------------------------
// usage
//   item   : sink channel; kind selects write byte, reader a read, reader b
//            read or clear. a beat is taken only while the block is idle
//   result : source channel; every result beat carries the free space and
//            both reader levels as they stand after the whole item
//   write, clear, discard and empty reads give one result beat, loaded into
//   the output register from the single state once the output is free
//   a read of n bytes gives n beats; the byte memory has one registered read
//   port, so each byte passes the read data register and then the output
//   register; bytes follow one a cycle when the result is not stalled
//   a stall on result holds the output register; the read sequencer keeps
//   at most one fetched byte waiting behind it and stops issuing reads
//   reset clears all ring indices, the burst total and the sequencer; the
//   byte store itself is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module dual_reader_byte_fifo_unit (
    input  wire         clk,
    input  wire         rst_n,
    drbf_in_if.sink     item,
    drbf_out_if.source  result
);
    import drbf_pkg::*;

    // byte store
    logic [7:0] mem [BUFFER_SLOTS];

    // control state
    state_t               state_reg, state_next;
    idx_t                 widx_reg, widx_next;
    idx_t                 rda_reg, rda_next;
    idx_t                 rdb_reg, rdb_next;
    logic [MOVED_W-1:0]   total_reg, total_next;
    idx_t                 rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 out_valid_reg, out_valid_next;

    // item scratch
    logic [MOVED_W-1:0]   moved_reg, moved_next;
    logic                 acc_reg, acc_next;
    logic                 last_pend_reg, last_pend_next;
    logic [7:0]           rdata_reg;

    // output register payload
    logic [7:0]           out_byte_reg;
    logic                 out_bvalid_reg;
    logic                 out_last_reg;
    logic                 out_acc_reg;
    logic [MOVED_W-1:0]   out_moved_reg;
    logic [STAT_W-1:0]    out_free_reg;
    logic [STAT_W-1:0]    out_la_reg;
    logic [STAT_W-1:0]    out_lb_reg;

    // handshake and sequencer strobes
    logic                 accept;
    logic                 out_free;
    logic                 load_single;
    logic                 load_burst;
    logic                 issue;
    logic                 mem_we;

    // read request working values
    status_t              status;
    idx_t                 start;
    idx_t                 lvl;
    logic [CNT_W-1:0]     cap;
    logic [CNT_W-1:0]     n;
    logic [IDX_W:0]       end_sum;
    idx_t                 end_idx;
    logic [MOVED_W-1:0]   total_inc;

    drbf_status u_status (
        .write_index    (widx_reg),
        .reader_a_index (rda_reg),
        .reader_b_index (rdb_reg),
        .status         (status)
    );

    // ------------------------------------------------------------------
    // sequencer strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        item.ready  = (state_reg == ST_IDLE);
        accept      = item.valid && (state_reg == ST_IDLE);
        out_free    = !out_valid_reg || result.ready;
        load_single = (state_reg == ST_SINGLE) && out_free;
        load_burst  = (state_reg == ST_BURST) && rd_pend_reg && out_free;
        // fetch the next byte when the waiting one moves on or none waits
        issue       = (state_reg == ST_BURST) && (remain_reg != '0)
                      && (!rd_pend_reg || load_burst);
        mem_we      = accept && (item.kind == K_WRITE)
                      && (status.free_space != '0);
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((item.kind inside {K_READ_A, K_READ_B})
                        && !item.discard && (n != '0))
                        state_next = ST_BURST;
                    else
                        state_next = ST_SINGLE;
                end
            end
            ST_SINGLE:
            begin
                if (load_single)
                    state_next = ST_IDLE;
            end
            ST_BURST:
            begin
                if (load_burst && last_pend_reg)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // read length: clip to the burst cap and to the reader level
    // ------------------------------------------------------------------
    always_comb
    begin
        start   = (item.kind == K_READ_A) ? rda_reg : rdb_reg;
        lvl     = (item.kind == K_READ_A) ? status.level_a : status.level_b;
        cap     = (item.count > REQ_W'(MAX_READ_BURST)) ? CNT_W'(MAX_READ_BURST)
                                                        : CNT_W'(item.count);
        n       = (CMP_W'(cap) > CMP_W'(lvl)) ? CNT_W'(lvl) : cap;
        end_sum = {1'b0, start} + (IDX_W + 1)'(n);
        end_idx = (end_sum >= SLOTS_X) ? IDX_W'(end_sum - SLOTS_X)
                                       : IDX_W'(end_sum);
        // burst total saturates at the top of its field
        total_inc = (total_reg != '1) ? total_reg + 1'b1 : total_reg;
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        widx_next      = widx_reg;
        rda_next       = rda_reg;
        rdb_next       = rdb_reg;
        total_next     = total_reg;
        rd_addr_next   = rd_addr_reg;
        remain_next    = remain_reg;
        moved_next     = moved_reg;
        acc_next       = acc_reg;
        last_pend_next = last_pend_reg;
        rd_pend_next   = rd_pend_reg;

        if (accept)
        begin
            case (item.kind)
                K_WRITE:
                begin
                    acc_next = mem_we;
                    if (mem_we)
                        widx_next = next_idx(widx_reg);
                    if (item.burst_last)
                    begin
                        moved_next = mem_we ? total_inc : total_reg;
                        total_next = '0;
                    end
                    else
                    begin
                        moved_next = '0;
                        total_next = mem_we ? total_inc : total_reg;
                    end
                end
                K_CLEAR:
                begin
                    widx_next  = '0;
                    rda_next   = '0;
                    rdb_next   = '0;
                    total_next = '0;
                    acc_next   = 1'b0;
                    moved_next = '0;
                end
                K_READ_A, K_READ_B:
                begin
                    // reader index moves at once, so status reads final
                    if (item.kind == K_READ_A)
                        rda_next = end_idx;
                    else
                        rdb_next = end_idx;
                    rd_addr_next = start;
                    remain_next  = item.discard ? '0 : n;
                    moved_next   = MOVED_W'(n);
                    acc_next     = 1'b0;
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end

        if (issue)
        begin
            rd_addr_next   = next_idx(rd_addr_reg);
            remain_next    = remain_reg - 1'b1;
            last_pend_next = (remain_reg == CNT_W'(1));
        end
        rd_pend_next = issue || (rd_pend_reg && !load_burst);

        if (load_single || load_burst)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            widx_reg      <= '0;
            rda_reg       <= '0;
            rdb_reg       <= '0;
            total_reg     <= '0;
            remain_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            rda_reg       <= rda_next;
            rdb_reg       <= rdb_next;
            total_reg     <= total_next;
            remain_reg    <= remain_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        moved_reg     <= moved_next;
        acc_reg       <= acc_next;
        last_pend_reg <= last_pend_next;
        if (load_single || load_burst)
        begin
            out_byte_reg   <= load_burst ? rdata_reg : 8'd0;
            out_bvalid_reg <= load_burst;
            out_last_reg   <= load_burst ? last_pend_reg : 1'b1;
            out_acc_reg    <= load_burst ? 1'b0 : acc_reg;
            out_moved_reg  <= moved_reg;
            out_free_reg   <= STAT_W'(status.free_space);
            out_la_reg     <= STAT_W'(status.level_a);
            out_lb_reg     <= STAT_W'(status.level_b);
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[widx_reg] <= item.data_byte;
        if (issue)
            rdata_reg <= mem[rd_addr_reg];
    end

    assign result.valid          = out_valid_reg;
    assign result.read_byte      = out_byte_reg;
    assign result.byte_valid     = out_bvalid_reg;
    assign result.last           = out_last_reg;
    assign result.write_accepted = out_acc_reg;
    assign result.moved_count    = out_moved_reg;
    assign result.free_space     = out_free_reg;
    assign result.level_a        = out_la_reg;
    assign result.level_b        = out_lb_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pend_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_BURST))
        else $error("fetched byte held outside a read burst");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (load_burst && last_pend_reg) |-> (remain_reg == '0))
        else $error("last byte delivered with reads still outstanding");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.kind == K_WRITE) && (status.free_space == '0))
        |=> $stable(widx_reg))
        else $error("write index moved on a full ring");

    a_remain_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BURST) |-> (remain_reg <= CNT_W'(MAX_READ_BURST)))
        else $error("read burst longer than the cap");

endmodule

`default_nettype wire
